@@ hdl/coffs_pkg.sv @@
// Package: shared types, constants and rounding multiply helper for the camera offset block.
`default_nettype none
package coffs_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int TRIG_FRACTION_BITS = 15;
	localparam int TRIG_W = TRIG_FRACTION_BITS + 2;
	localparam int OFS_W = 24;
	localparam int COORD_W = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_OFFSET_RIGHT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_UP      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_FORWARD = 2'd2;

	localparam logic [31:0] Q30_ONE = 32'd1073741824;
	localparam logic [31:0] K1  = 32'd1686629713;
	localparam logic [31:0] K3  = 32'd693598668;
	localparam logic [31:0] K5  = 32'd85569306;
	localparam logic [31:0] K7  = 32'd5026995;
	localparam logic [31:0] K9  = 32'd172272;
	localparam logic [31:0] K11 = 32'd3864;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic [ANGLE_BITS-1:0] pitch_angle;
		logic [ANGLE_BITS-1:0] yaw_angle;
		logic [ANGLE_BITS-1:0] roll_angle;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] shifted_x;
		logic signed [COORD_W-1:0] shifted_y;
		logic signed [COORD_W-1:0] shifted_z;
	} out_item_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] right;
		logic signed [OFS_W-1:0] up;
		logic signed [OFS_W-1:0] forward;
	} offsets_t;

	// round a signed product to Q(TRIG_FRACTION_BITS), floor of value plus half
	function automatic logic signed [TRIG_W-1:0] tmul(input logic signed [TRIG_W-1:0] a,
			input logic signed [TRIG_W-1:0] b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b + (2*TRIG_W)'(signed'(1) <<< (TRIG_FRACTION_BITS - 1));
		return TRIG_W'(p >>> TRIG_FRACTION_BITS);
	endfunction
endpackage
`default_nettype wire

@@ hdl/coffs_sine.sv @@
// Pipelined fixed-point sine: one Horner step per register stage.
`default_nettype none
module coffs_sine (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire logic [coffs_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [coffs_pkg::TRIG_W-1:0] sine
);
	localparam int NSTEP = 6;
	localparam int FB = coffs_pkg::ANGLE_BITS - 2;

	logic [30:0] t_s [0:NSTEP+1];
	logic [30:0] u_s [0:NSTEP+1];
	logic [31:0] p_s [0:NSTEP+1];
	logic neg_s [0:NSTEP+1];
	logic [30:0] t0;
	logic [61:0] tt;
	logic [31:0] coef [0:4];
	logic [61:0] pu [0:4];
	logic [62:0] tp;
	logic [31:0] r;
	logic [31:0] rr;

	assign coef[0] = coffs_pkg::K9;
	assign coef[1] = coffs_pkg::K7;
	assign coef[2] = coffs_pkg::K5;
	assign coef[3] = coffs_pkg::K3;
	assign coef[4] = coffs_pkg::K1;

	always_comb begin
		t0 = 31'({angle[FB-1:0], (30-FB)'(0)});
		if (angle[FB]) t0 = 31'(coffs_pkg::Q30_ONE) - t0;
		tt = t0 * t0;
	end

	// stage 0: quadrant fold and square
	always_ff @(posedge clk) begin
		if (advance) begin
			t_s[0] <= t0;
			u_s[0] <= 31'(tt >> 30);
			p_s[0] <= coffs_pkg::K11;
			neg_s[0] <= angle[FB+1];
		end
	end

	for (genvar k = 0; k < 5; k++) begin : g_horner
		assign pu[k] = 62'(p_s[k] * u_s[k]);
		always_ff @(posedge clk) begin
			if (advance) begin
				t_s[k+1] <= t_s[k];
				u_s[k+1] <= u_s[k];
				p_s[k+1] <= coef[k] - 32'(pu[k] >> 30);
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign tp = 63'(t_s[5] * p_s[5]);
	always_comb begin
		r = 32'(tp >> 30);
		rr = (r + (32'd1 << (29 - coffs_pkg::TRIG_FRACTION_BITS)))
			>> (30 - coffs_pkg::TRIG_FRACTION_BITS);
		if (rr > (32'd1 << coffs_pkg::TRIG_FRACTION_BITS))
			rr = 32'd1 << coffs_pkg::TRIG_FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s[6] <= neg_s[5] ? -rr : rr;
			t_s[6] <= t_s[5];
			u_s[6] <= u_s[5];
			neg_s[6] <= neg_s[5];
		end
	end
	assign t_s[7] = t_s[6];
	assign u_s[7] = u_s[6];
	assign p_s[7] = p_s[6];
	assign neg_s[7] = neg_s[6];
	assign sine = coffs_pkg::TRIG_W'(p_s[7]);

	logic unused;
	assign unused = ^{arst_n, t_s[7], u_s[7], neg_s[7]};
endmodule
`default_nettype wire

@@ hdl/coffs_basis.sv @@
// Basis vector pipeline: forward, right and up from sines and cosines.
`default_nettype none
module coffs_basis (
	input  wire logic clk,
	input  wire logic advance,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] sp,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] cp,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] sy,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] cy,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] sr,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] cr,
	output logic signed [coffs_pkg::TRIG_W-1:0] vec [0:8]
);
	localparam int W = coffs_pkg::TRIG_W;
	logic signed [W-1:0] srsp_s1, crsp_s1, sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	logic signed [W-1:0] fx_s1, fy_s1, rz_s1, uz_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			srsp_s1 <= coffs_pkg::tmul(sr, sp);
			crsp_s1 <= coffs_pkg::tmul(cr, sp);
			fx_s1 <= coffs_pkg::tmul(cp, cy);
			fy_s1 <= coffs_pkg::tmul(cp, sy);
			rz_s1 <= -coffs_pkg::tmul(sr, cp);
			uz_s1 <= coffs_pkg::tmul(cr, cp);
			sp_s1 <= sp; cp_s1 <= cp; sy_s1 <= sy; cy_s1 <= cy; sr_s1 <= sr; cr_s1 <= cr;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vec[0] <= fx_s1;
			vec[1] <= fy_s1;
			vec[2] <= -sp_s1;
			vec[3] <= coffs_pkg::tmul(cr_s1, sy_s1) - coffs_pkg::tmul(srsp_s1, cy_s1);
			vec[4] <= -coffs_pkg::tmul(srsp_s1, sy_s1) - coffs_pkg::tmul(cr_s1, cy_s1);
			vec[5] <= rz_s1;
			vec[6] <= coffs_pkg::tmul(crsp_s1, cy_s1) + coffs_pkg::tmul(sr_s1, sy_s1);
			vec[7] <= coffs_pkg::tmul(crsp_s1, sy_s1) - coffs_pkg::tmul(sr_s1, cy_s1);
			vec[8] <= uz_s1;
		end
	end
	logic unused;
	assign unused = ^cp_s1;
endmodule
`default_nettype wire

@@ hdl/coffs_shift.sv @@
// One coordinate shift: three offset products, sum, round, add and saturate.
`default_nettype none
module coffs_shift (
	input  wire logic clk,
	input  wire logic advance,
	input  wire coffs_pkg::offsets_t ofs,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] fv,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] rv,
	input  wire logic signed [coffs_pkg::TRIG_W-1:0] uv,
	input  wire logic signed [coffs_pkg::COORD_W-1:0] origin,
	output logic signed [coffs_pkg::COORD_W-1:0] shifted
);
	localparam int PW = coffs_pkg::OFS_W + coffs_pkg::TRIG_W;
	localparam int SW = PW + 2;
	logic signed [PW-1:0] pf_s1, pr_s1, pu_s1;
	logic signed [coffs_pkg::COORD_W-1:0] org_s1, org_s2;
	logic signed [SW-1:0] sum_s2;
	logic signed [SW-1:0] rnd;
	logic signed [SW+1:0] v;

	always_ff @(posedge clk) begin
		if (advance) begin
			pf_s1 <= PW'(ofs.forward * fv);
			pr_s1 <= PW'(ofs.right * rv);
			pu_s1 <= PW'(ofs.up * uv);
			org_s1 <= origin;
			sum_s2 <= SW'(pf_s1) + SW'(pr_s1) + SW'(pu_s1);
			org_s2 <= org_s1;
		end
	end

	always_comb begin
		rnd = (sum_s2 + SW'(signed'(1) <<< (coffs_pkg::TRIG_FRACTION_BITS - 1)))
			>>> coffs_pkg::TRIG_FRACTION_BITS;
		v = (SW+2)'(org_s2) + (SW+2)'(rnd);
		if (v > (SW+2)'(signed'(33'sh0_7FFF_FFFF))) shifted = 32'sh7FFF_FFFF;
		else if (v < -(SW+2)'(signed'(34'sh0_8000_0000))) shifted = 32'sh8000_0000;
		else shifted = coffs_pkg::COORD_W'(v);
	end
endmodule
`default_nettype wire

@@ hdl/camera_offset_from_euler_angles_unit.sv @@
// Top level: camera offset from Euler angles, stalling pipeline.
// Usage:
//   Input channel in_valid/in_stall/in_data carries origin and three angles.
//   Output channel out_valid/out_stall/out_data carries the shifted origin.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the offsets
//   (0 right, 1 up, 2 forward); cfg_ready is always high.
// Throughput: one item per cycle while the output is not stalled; the pipeline
//   holds the sine Horner stages (one multiply per stage) and the basis and shift product stages.
// Stall: a stalled output freezes the whole pipeline; while the output slot
//   is empty the pipeline keeps moving, so nothing is lost or repeated.
// Reset: clears all valid bits and the offset registers to zero.
`default_nettype none
module camera_offset_from_euler_angles_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire coffs_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output coffs_pkg::out_item_t out_data,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [coffs_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [coffs_pkg::OFS_W-1:0] cfg_data
);
	localparam int DEPTH = 12;
	localparam int W = coffs_pkg::TRIG_W;
	localparam int OD = 9;

	coffs_pkg::offsets_t ofs_q;
	logic [DEPTH-1:0] vld_q;
	logic advance;
	logic signed [W-1:0] sp, cp, sy, cy, sr, cr;
	logic signed [W-1:0] vec [0:8];
	logic signed [coffs_pkg::COORD_W-1:0] org_s [0:OD][0:2];
	logic signed [coffs_pkg::COORD_W-1:0] sh [0:2];

	// whole pipeline moves unless the last item is held
	assign advance = !(vld_q[DEPTH-1] && out_stall);
	assign in_stall = !advance;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ofs_q <= '0;
		end else begin
			if (advance) vld_q <= {vld_q[DEPTH-2:0], in_valid};
			if (cfg_valid) begin
				case (cfg_index)
					coffs_pkg::REG_OFFSET_RIGHT: ofs_q.right <= cfg_data;
					coffs_pkg::REG_OFFSET_UP: ofs_q.up <= cfg_data;
					coffs_pkg::REG_OFFSET_FORWARD: ofs_q.forward <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	localparam logic [coffs_pkg::ANGLE_BITS-1:0] QTR =
		coffs_pkg::ANGLE_BITS'(1) << (coffs_pkg::ANGLE_BITS - 2);
	coffs_sine u_sp (.clk, .arst_n, .advance, .angle(in_data.pitch_angle), .sine(sp));
	coffs_sine u_cp (.clk, .arst_n, .advance, .angle(in_data.pitch_angle + QTR), .sine(cp));
	coffs_sine u_sy (.clk, .arst_n, .advance, .angle(in_data.yaw_angle), .sine(sy));
	coffs_sine u_cy (.clk, .arst_n, .advance, .angle(in_data.yaw_angle + QTR), .sine(cy));
	coffs_sine u_sr (.clk, .arst_n, .advance, .angle(in_data.roll_angle), .sine(sr));
	coffs_sine u_cr (.clk, .arst_n, .advance, .angle(in_data.roll_angle + QTR), .sine(cr));

	coffs_basis u_basis (.clk, .advance, .sp, .cp, .sy, .cy, .sr, .cr, .vec);

	// carry the origin alongside trig and basis stages
	assign org_s[0][0] = in_data.origin_x;
	assign org_s[0][1] = in_data.origin_y;
	assign org_s[0][2] = in_data.origin_z;
	for (genvar k = 0; k < OD; k++) begin : g_org
		always_ff @(posedge clk) begin
			if (advance) org_s[k+1] <= org_s[k];
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_shift
		coffs_shift u_shift (.clk, .advance, .ofs(ofs_q), .fv(vec[c]), .rv(vec[3+c]),
			.uv(vec[6+c]), .origin(org_s[OD][c]), .shifted(sh[c]));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.shifted_x <= sh[0];
			out_data.shifted_y <= sh[1];
			out_data.shifted_z <= sh[2];
		end
	end

`ifndef ASSERT_OFF
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_valid_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> vld_q[0] == $past(in_valid))
		else $error("valid bit lost at entry");
`endif
endmodule
`default_nettype wire

@@ test/camera_offset_from_euler_angles_unit_tb.sv @@
// Testbench: camera offset from Euler angles, checked against a fixed-point predictor.
`timescale 1ns / 100ps
`default_nettype none
module camera_offset_from_euler_angles_unit_tb;
	import coffs_pkg::*;

	typedef struct {
		in_item_t  view;
		bit        known;
		out_item_t shifted;
	} view_row_t;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [OFS_W-1:0] cfg_data;

	offsets_t offs;
	out_item_t shifted_q[$];
	view_row_t rows[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int results_seen;
	int views_sent;
	int cycles;
	int in_stall_seen;
	bit hold_go;
	logic hold_on;

	camera_offset_from_euler_angles_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// sine of a binary angle, Q15, from the quarter-turn polynomial
	function automatic longint angle_sine(logic [ANGLE_BITS-1:0] a);
		longint unsigned t, u, p, r;
		logic [1:0] quad;
		quad = a[ANGLE_BITS-1 -: 2];
		t = longint'(a[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
		if (quad[0])
			t = longint'(Q30_ONE) - t;
		u = (t * t) >> 30;
		p = longint'(K11);
		p = longint'(K9) - ((p * u) >> 30);
		p = longint'(K7) - ((p * u) >> 30);
		p = longint'(K5) - ((p * u) >> 30);
		p = longint'(K3) - ((p * u) >> 30);
		p = longint'(K1) - ((p * u) >> 30);
		r = (t * p) >> 30;
		r = (r + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
		if (r > (64'd1 << TRIG_FRACTION_BITS))
			r = 64'd1 << TRIG_FRACTION_BITS;
		return quad[1] ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint round_q15(longint v);
		return (v + (longint'(1) << (TRIG_FRACTION_BITS - 1))) >>> TRIG_FRACTION_BITS;
	endfunction

	function automatic logic signed [COORD_W-1:0] move_coord(logic signed [COORD_W-1:0] o,
			longint f, longint r, longint u);
		longint v;
		v = longint'(o) + round_q15(longint'(offs.forward) * f + longint'(offs.right) * r
			+ longint'(offs.up) * u);
		if (v > 64'sh7fffffff)
			v = 64'sh7fffffff;
		if (v < -64'sh80000000)
			v = -64'sh80000000;
		return v[COORD_W-1:0];
	endfunction

	function automatic out_item_t shift_view(in_item_t v);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		longint fx, fy, fz, rx, ry, rz, ux, uy, uz;
		out_item_t o;
		sp = angle_sine(v.pitch_angle);
		cp = angle_sine(v.pitch_angle + QUARTER_TURN);
		sy = angle_sine(v.yaw_angle);
		cy = angle_sine(v.yaw_angle + QUARTER_TURN);
		sr = angle_sine(v.roll_angle);
		cr = angle_sine(v.roll_angle + QUARTER_TURN);
		srsp = round_q15(sr * sp);
		crsp = round_q15(cr * sp);
		fx = round_q15(cp * cy);
		fy = round_q15(cp * sy);
		fz = -sp;
		rx = -round_q15(srsp * cy) + round_q15(cr * sy);
		ry = -round_q15(srsp * sy) - round_q15(cr * cy);
		rz = -round_q15(sr * cp);
		ux = round_q15(crsp * cy) + round_q15(sr * sy);
		uy = round_q15(crsp * sy) - round_q15(sr * cy);
		uz = round_q15(cr * cp);
		o.shifted_x = move_coord(v.origin_x, fx, rx, ux);
		o.shifted_y = move_coord(v.origin_y, fy, ry, uy);
		o.shifted_z = move_coord(v.origin_z, fz, rz, uz);
		return o;
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(2000) - 1000;
			1: return 32'sh7fffffff - $urandom_range(100000);
			2: return 32'sh80000000 + $urandom_range(100000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ANGLE_BITS-1:0] rand_angle();
		if ($urandom_range(7) == 0)
			return ANGLE_BITS'($urandom_range(7)) << (ANGLE_BITS - 3);
		return ANGLE_BITS'($urandom);
	endfunction

	function automatic in_item_t rand_view();
		in_item_t v;
		v.origin_x = rand_coord();
		v.origin_y = rand_coord();
		v.origin_z = rand_coord();
		v.pitch_angle = rand_angle();
		v.yaw_angle = rand_angle();
		v.roll_angle = rand_angle();
		return v;
	endfunction

	function automatic in_item_t mk_view(logic signed [COORD_W-1:0] x, y, z,
			logic [ANGLE_BITS-1:0] p, yw, r);
		in_item_t v;
		v.origin_x = x;
		v.origin_y = y;
		v.origin_z = z;
		v.pitch_angle = p;
		v.yaw_angle = yw;
		v.roll_angle = r;
		return v;
	endfunction

	task automatic send_view(in_item_t v, bit known, out_item_t typed);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (in_stall);
		shifted_q.push_back(known ? typed : shift_view(v));
		views_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (shifted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(logic [REG_IDX_W-1:0] idx, logic [OFS_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_OFFSET_RIGHT: offs.right = val;
			REG_OFFSET_UP: offs.up = val;
			REG_OFFSET_FORWARD: offs.forward = val;
			default: ;  // unmapped index, ignored
		endcase
	endtask

	task automatic write_all(logic [OFS_W-1:0] r, u, f);
		write_offset(REG_OFFSET_RIGHT, r);
		write_offset(REG_OFFSET_UP, u);
		write_offset(REG_OFFSET_FORWARD, f);
	endtask

	task automatic run_random(int n);
		out_item_t none;
		none = '0;
		repeat (n)
			send_view(rand_view(), 1'b0, none);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (shifted_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				out_item_t want;
				want = shifted_q.pop_front();
				if (want.shifted_x !== out_data.shifted_x || want.shifted_y !== out_data.shifted_y
						|| want.shifted_z !== out_data.shifted_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h, got %h %h %h",
							want.shifted_x, want.shifted_y, want.shifted_z,
							out_data.shifted_x, out_data.shifted_y, out_data.shifted_z);
				end
			end
		end
		if (in_valid && in_stall)
			in_stall_seen++;
		out_stall <= hold_on || (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	// long receiver hold-off, timed here
	always begin
		@(posedge hold_go);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		out_item_t none;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_go = 1'b0;
		hold_on = 1'b0;
		offs = '0;
		none = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		views_sent = 0;
		cycles = 0;
		in_stall_seen = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// offsets are zero after reset: the origin passes through untouched
		rows.push_back('{mk_view(0, 0, 0, 0, 0, 0), 1, '{0, 0, 0}});
		rows.push_back('{mk_view(32'sh7fffffff, 32'sh80000000, -1, 16'hffff, 16'hffff, 16'hffff),
			1, '{32'sh7fffffff, 32'sh80000000, -1}});
		rows.push_back('{mk_view(32'sh80000000, 32'sh7fffffff, 256, 16'h4000, 16'h8000, 16'hc000),
			1, '{32'sh80000000, 32'sh7fffffff, 256}});
		rows.push_back('{mk_view(12345, -678, 99, 16'h2000, 16'h6000, 16'ha000),
			1, '{12345, -678, 99}});
		foreach (rows[i])
			send_view(rows[i].view, rows[i].known, rows[i].shifted);
		rows.delete();

		// extreme offsets, quadrant edges and saturation
		write_all(24'h7fffff, 24'h7fffff, 24'h7fffff);
		write_offset(REG_UNMAPPED, 24'h123456);
		rows.push_back('{mk_view(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0), 0, none});
		rows.push_back('{mk_view(32'sh80000000, 32'sh80000000, 32'sh80000000,
			16'h8000, 16'h8000, 16'h8000), 0, none});
		rows.push_back('{mk_view(0, 0, 0, 16'h4000, 16'h4000, 16'h4000), 0, none});
		rows.push_back('{mk_view(0, 0, 0, 16'hc000, 16'hc000, 16'hc000), 0, none});
		rows.push_back('{mk_view(0, 0, 0, 16'h3fff, 16'h7fff, 16'hbfff), 0, none});
		rows.push_back('{mk_view(-1, 1, 0, 16'hffff, 16'h0001, 16'h4001), 0, none});
		foreach (rows[i])
			send_view(rows[i].view, 1'b0, none);
		write_all(24'h800000, 24'h800000, 24'h800000);
		foreach (rows[i])
			send_view(rows[i].view, 1'b0, none);
		write_all(24'h000100, 24'hffff00, 24'h800000);
		foreach (rows[i])
			send_view(rows[i].view, 1'b0, none);

		// random views over the stall mixes and several offset settings
		write_all(OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
		run_random(390);
		send_idle_pct = 50;
		write_all(24'h7fffff, 24'h800000, 24'h000001);
		run_random(390);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		write_all(OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
		run_random(390);
		send_idle_pct = 9;
		recv_stall_pct = 9;
		write_all(OFS_W'($urandom_range(4095)), OFS_W'($urandom_range(4095)),
			OFS_W'($urandom_range(4095)));
		run_random(390);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
		hold_go = 1'b1;
		run_random(360);

		wait_idle();
		$display("Sent %0d views through %0d offset settings and four stall mixes,",
			views_sent, 9);
		$display("checked %0d results; input held off on %0d cycles.", results_seen,
			in_stall_seen);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/coffs_pkg.sv
hdl/coffs_sine.sv
hdl/coffs_basis.sv
hdl/coffs_shift.sv
hdl/camera_offset_from_euler_angles_unit.sv
test/camera_offset_from_euler_angles_unit_tb.sv
